FILE: hdl/sdi_pkg.sv
package sdi_pkg;

   localparam int MAX_SAMPLES = 65536;
   localparam int CountWidth = $clog2(MAX_SAMPLES);

   localparam int SampleWidth = 24;
   localparam int StepWidth = 24;
   localparam int SumWidth = 48;
   localparam int NumWidth = 52;
   localparam int IntegralWidth = 64;
   localparam int CsrDataWidth = 32;
   localparam int CsrAddrWidth = 3;
   localparam int RegSelBit = 2;

   localparam logic [StepWidth-1:0] StepReset = 24'd65536;

   // mag = H*2^24 + L and 2^24 = 3*SplitThird + 1
   localparam int HalfWidth = 24;
   localparam int HighWidth = NumWidth - HalfWidth;
   localparam int HlWidth = HighWidth + 1;
   localparam int SplitThirdWidth = 23;
   localparam logic [SplitThirdWidth-1:0] SplitThird = 23'd5592405;
   localparam int HkWidth = HighWidth + SplitThirdWidth;

   // floor(x/3) = (x * Recip) >> RecipShift for x < 2^RecipShift
   localparam int RecipShift = 31;
   localparam int RecipWidth = 30;
   localparam logic [RecipWidth-1:0] Recip = 30'd715827883;
   localparam int HlmWidth = HlWidth + RecipWidth;

   localparam int LoProdWidth = HalfWidth + StepWidth;
   localparam int HiProdWidth = HighWidth + StepWidth;
   localparam int ProductWidth = NumWidth + StepWidth;
   localparam int EWidth = StepWidth + 1;
   localparam int EmWidth = EWidth + RecipWidth;

   localparam int FifoDepth = 4;
   localparam int FifoPtrWidth = $clog2(FifoDepth);
   localparam int FifoCountWidth = $clog2(FifoDepth + 1);

   typedef enum logic [1:0] {
      METHOD_RECTANGLE,
      METHOD_TRAPEZOID,
      METHOD_SIMPSON,
      METHOD_CUMULATIVE
   } method_type;

   typedef enum logic [1:0] {
      DIV_ONE,
      DIV_TWO,
      DIV_THREE,
      DIV_SIX
   } divisor_type;

   typedef enum logic {
      REG_METHOD,
      REG_STEP_WIDTH
   } reg_index_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] sample;
      logic                          final_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [IntegralWidth-1:0] integral;
      logic                            saturated;
      logic                            set_done;
      logic                            run_last;
   } rsp_payload_type;

   typedef struct packed {
      method_type           method;
      logic [StepWidth-1:0] step_width;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic                 lead_zero;
      logic                 done;
      divisor_type          divisor;
      logic [StepWidth-1:0] dx;
   } side_type;

   typedef struct packed {
      side_type                   side;
      logic signed [NumWidth-1:0] num;
   } num_item_type;

   typedef struct packed {
      logic            valid;
      logic            lead_zero;
      rsp_payload_type result;
   } push_type;

endpackage

FILE: hdl/sdi_csr.sv
module sdi_csr import sdi_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   method_type           method_ff, method_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic                 write_en;
   reg_index_type        index;

   assign csr_pready = 1'b1;
   assign write_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign index = reg_index_type'(csr_paddr[RegSelBit]);

   always_comb begin
      method_in = method_ff;
      step_in = step_ff;
      if (write_en) begin
         unique case (index)
            REG_METHOD:     method_in = method_type'(csr_pwdata[1:0]);
            REG_STEP_WIDTH: step_in = csr_pwdata[StepWidth-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         REG_METHOD:     csr_prdata = CsrDataWidth'(method_ff);
         REG_STEP_WIDTH: csr_prdata = CsrDataWidth'(step_ff);
         default:        ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= METHOD_TRAPEZOID;
         step_ff <= StepReset;
      end else begin
         method_ff <= method_in;
         step_ff <= step_in;
      end
   end

   assign cfg.method = method_ff;
   assign cfg.step_width = step_ff;

endmodule

FILE: hdl/sdi_accum.sv
module sdi_accum import sdi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  cfg_type         cfg,
   input  logic            req_valid,
   input  req_payload_type req_payload,
   output num_item_type    item
);

   logic                          in_valid_ff, in_valid_in;
   req_payload_type               in_data_ff, in_data_in;
   logic signed [SumWidth-1:0]    first_ff, first_in;
   logic signed [SumWidth-1:0]    prev_ff, prev_in;
   logic signed [SumWidth-1:0]    odd_ff, odd_in;
   logic signed [SumWidth-1:0]    even_ff, even_in;
   logic signed [SumWidth-1:0]    pair_ff, pair_in;
   logic [CountWidth-1:0]         count_ff, count_in;
   num_item_type                  item_ff, item_in;

   logic signed [SampleWidth-1:0] sample_s;
   logic signed [SumWidth-1:0]    s_ext;
   logic signed [SumWidth-1:0]    new_odd, new_even, new_pair;
   logic                          idx_zero, idx_one, idx_odd, fin, step;
   logic [StepWidth-1:0]          dx;
   logic signed [NumWidth-1:0]    rect_num, simp_even_num, simp_odd_num, simp_t, ps;

   assign sample_s = in_data_ff.sample;
   assign s_ext = SumWidth'(sample_s);
   assign idx_zero = (count_ff == '0);
   assign idx_one = (count_ff == CountWidth'(1));
   assign idx_odd = count_ff[0];
   assign fin = in_data_ff.final_sample | (count_ff == CountWidth'(MAX_SAMPLES - 1));
   assign step = advance & in_valid_ff;
   assign dx = (cfg.step_width == '0) ? StepReset : cfg.step_width;

   assign new_odd = idx_zero ? '0 : (idx_odd ? odd_ff + s_ext : odd_ff);
   assign new_even = idx_zero ? s_ext : (idx_odd ? even_ff : even_ff + s_ext);
   assign new_pair = idx_zero ? '0 : pair_ff + prev_ff + s_ext;

   assign rect_num = NumWidth'(new_odd) + NumWidth'(new_even) - NumWidth'(s_ext);
   assign simp_even_num = (NumWidth'(new_odd) <<< 2) + (NumWidth'(new_even) <<< 1)
                          - NumWidth'(first_ff) - NumWidth'(s_ext);
   assign simp_t = (NumWidth'(odd_ff) <<< 2) + (NumWidth'(new_even) <<< 1)
                   - NumWidth'(first_ff) - NumWidth'(prev_ff);
   assign ps = NumWidth'(prev_ff) + NumWidth'(s_ext);
   assign simp_odd_num = (simp_t <<< 1) + ps + (ps <<< 1);

   always_comb begin
      item_in = '0;
      item_in.side.dx = dx;
      if (in_valid_ff) begin
         if (cfg.method == METHOD_CUMULATIVE) begin
            item_in.side.valid = !idx_zero;
            item_in.side.lead_zero = idx_one;
            item_in.side.done = fin;
            item_in.side.divisor = DIV_TWO;
            item_in.num = NumWidth'(new_pair);
         end else if (fin) begin
            item_in.side.valid = 1'b1;
            item_in.side.done = 1'b1;
            if (idx_zero) begin
               item_in.side.divisor = DIV_ONE;
               item_in.num = '0;
            end else if (cfg.method == METHOD_RECTANGLE) begin
               item_in.side.divisor = DIV_ONE;
               item_in.num = rect_num;
            end else if (cfg.method == METHOD_TRAPEZOID || idx_one) begin
               item_in.side.divisor = DIV_TWO;
               item_in.num = NumWidth'(new_pair);
            end else if (!idx_odd) begin
               item_in.side.divisor = DIV_THREE;
               item_in.num = simp_even_num;
            end else begin
               item_in.side.divisor = DIV_SIX;
               item_in.num = simp_odd_num;
            end
         end
      end
   end

   always_comb begin
      in_valid_in = advance ? req_valid : in_valid_ff;
      in_data_in = advance ? req_payload : in_data_ff;
      first_in = (step && idx_zero) ? s_ext : first_ff;
      odd_in = step ? new_odd : odd_ff;
      even_in = step ? new_even : even_ff;
      pair_in = step ? new_pair : pair_ff;
      prev_in = step ? s_ext : prev_ff;
      count_in = count_ff;
      if (step) begin
         count_in = fin ? '0 : count_ff + CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff <= '0;
         item_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff <= count_in;
         if (advance) begin
            item_ff <= item_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      first_ff <= first_in;
      prev_ff <= prev_in;
      odd_ff <= odd_in;
      even_ff <= even_in;
      pair_ff <= pair_in;
   end

   assign item = item_ff;

endmodule

FILE: hdl/sdi_scale.sv
module sdi_scale import sdi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  num_item_type item,
   output push_type     push
);

   typedef struct packed {
      side_type            side;
      logic                neg;
      logic [NumWidth-1:0] mag;
   } mag_stage_type;

   typedef struct packed {
      side_type            side;
      logic                neg;
      logic [NumWidth-1:0] mag;
      logic [HkWidth-1:0]  hk;
      logic [HlWidth-1:0]  hl;
      logic [HlmWidth-1:0] hlm;
   } split_stage_type;

   typedef struct packed {
      side_type            side;
      logic                neg;
      logic [NumWidth-1:0] a;
      logic [1:0]          r;
   } third_stage_type;

   typedef struct packed {
      side_type               side;
      logic                   neg;
      logic [LoProdWidth-1:0] plo;
      logic [HiProdWidth-1:0] phi;
      logic [EWidth-1:0]      e;
   } part_stage_type;

   typedef struct packed {
      side_type                side;
      logic                    neg;
      logic [ProductWidth-1:0] p;
      logic [EmWidth-1:0]      em;
      logic [EWidth-1:0]       e;
   } sum_stage_type;

   typedef struct packed {
      side_type                side;
      logic                    neg;
      logic [ProductWidth-1:0] quot;
      logic [1:0]              rem;
   } quot_stage_type;

   localparam logic [IntegralWidth-1:0] PosLimit = {1'b0, {(IntegralWidth-1){1'b1}}};
   localparam logic [IntegralWidth-1:0] NegLimit = {1'b1, {(IntegralWidth-1){1'b0}}};

   mag_stage_type   st2_ff, st2_in;
   split_stage_type st3_ff, st3_in;
   third_stage_type st4_ff, st4_in;
   part_stage_type  st5_ff, st5_in;
   sum_stage_type   st6_ff, st6_in;
   quot_stage_type  st7_ff, st7_in;

   logic [HighWidth-1:0] h;
   logic [HalfWidth-1:0] l;
   logic [HighWidth-1:0] qhl;
   logic [HlWidth-1:0]   rhl;
   logic                 is_third;
   logic [StepWidth-1:0] qe;
   logic [EWidth-1:0]    re;

   // magnitude
   always_comb begin
      st2_in.side = item.side;
      st2_in.neg = item.num[NumWidth-1];
      st2_in.mag = item.num[NumWidth-1] ? NumWidth'(-item.num) : NumWidth'(item.num);
   end

   // split into halves, reciprocal multiply for the low-order third
   assign h = st2_ff.mag[NumWidth-1:HalfWidth];
   assign l = st2_ff.mag[HalfWidth-1:0];

   always_comb begin
      st3_in.side = st2_ff.side;
      st3_in.neg = st2_ff.neg;
      st3_in.mag = st2_ff.mag;
      st3_in.hk = HkWidth'(h) * HkWidth'(SplitThird);
      st3_in.hl = HlWidth'(h) + HlWidth'(l);
      st3_in.hlm = HlmWidth'(st3_in.hl) * HlmWidth'(Recip);
   end

   // a = floor(mag/3), r = mag mod 3 for the thirds; else pass the magnitude
   assign qhl = st3_ff.hlm[RecipShift +: HighWidth];
   assign rhl = st3_ff.hl - (HlWidth'(qhl) + (HlWidth'(qhl) << 1));
   assign is_third = (st3_ff.side.divisor == DIV_THREE) || (st3_ff.side.divisor == DIV_SIX);

   always_comb begin
      st4_in.side = st3_ff.side;
      st4_in.neg = st3_ff.neg;
      st4_in.a = is_third ? NumWidth'(st3_ff.hk) + NumWidth'(qhl) : st3_ff.mag;
      st4_in.r = is_third ? rhl[1:0] : 2'd0;
   end

   // partial products of a*dx, and r*dx
   always_comb begin
      st5_in.side = st4_ff.side;
      st5_in.neg = st4_ff.neg;
      st5_in.plo = LoProdWidth'(st4_ff.a[HalfWidth-1:0]) * LoProdWidth'(st4_ff.side.dx);
      st5_in.phi = HiProdWidth'(st4_ff.a[NumWidth-1:HalfWidth])
                   * HiProdWidth'(st4_ff.side.dx);
      case (st4_ff.r)
         2'd1:    st5_in.e = EWidth'(st4_ff.side.dx);
         2'd2:    st5_in.e = EWidth'(st4_ff.side.dx) << 1;
         default: st5_in.e = '0;
      endcase
   end

   // combine partials, reciprocal multiply for r*dx / 3
   always_comb begin
      st6_in.side = st5_ff.side;
      st6_in.neg = st5_ff.neg;
      st6_in.p = (ProductWidth'(st5_ff.phi) << HalfWidth) + ProductWidth'(st5_ff.plo);
      st6_in.em = EmWidth'(st5_ff.e) * EmWidth'(Recip);
      st6_in.e = st5_ff.e;
   end

   // floor(mag*dx/3) or mag*dx, with remainder mod 3
   assign qe = st6_ff.em[RecipShift +: StepWidth];
   assign re = st6_ff.e - (EWidth'(qe) + (EWidth'(qe) << 1));

   always_comb begin
      st7_in.side = st6_ff.side;
      st7_in.neg = st6_ff.neg;
      st7_in.quot = st6_ff.p + ProductWidth'(qe);
      st7_in.rem = re[1:0];
   end

   // round half away from zero, clamp, restore sign
   always_comb begin
      logic [ProductWidth-1:0]  q;
      logic                     rnd;
      logic [IntegralWidth-1:0] qsum;
      logic [IntegralWidth-1:0] mag_out;
      logic                     sat;
      q = st7_ff.quot;
      rnd = 1'b0;
      case (st7_ff.side.divisor)
         DIV_ONE: begin
            q = st7_ff.quot;
            rnd = 1'b0;
         end
         DIV_TWO, DIV_SIX: begin
            q = st7_ff.quot >> 1;
            rnd = st7_ff.quot[0];
         end
         DIV_THREE: begin
            q = st7_ff.quot;
            rnd = st7_ff.rem[1];
         end
         default: ;
      endcase
      qsum = q[IntegralWidth-1:0] + IntegralWidth'(rnd);
      sat = (|q[ProductWidth-1:IntegralWidth-1]) || (!st7_ff.neg && qsum[IntegralWidth-1]);
      if (sat) begin
         mag_out = st7_ff.neg ? NegLimit : PosLimit;
      end else begin
         mag_out = qsum;
      end
      push.valid = st7_ff.side.valid;
      push.lead_zero = st7_ff.side.lead_zero;
      push.result.integral = st7_ff.neg ? -mag_out : mag_out;
      push.result.saturated = sat;
      push.result.set_done = st7_ff.side.done;
      push.result.run_last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_ff <= '0;
         st3_ff <= '0;
         st4_ff <= '0;
         st5_ff <= '0;
         st6_ff <= '0;
         st7_ff <= '0;
      end else if (advance) begin
         st2_ff <= st2_in;
         st3_ff <= st3_in;
         st4_ff <= st4_in;
         st5_ff <= st5_in;
         st6_ff <= st6_in;
         st7_ff <= st7_in;
      end
   end

endmodule

FILE: hdl/sdi_out_fifo.sv
module sdi_out_fifo import sdi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   output logic            advance,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   rsp_payload_type           mem_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCountWidth-1:0] count_ff, count_in;
   logic                      do_push, do_pop;
   logic [FifoCountWidth-1:0] push_n;
   rsp_payload_type           zero_result;

   assign advance = (count_ff <= FifoCountWidth'(FifoDepth - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_payload = mem_ff[rd_ptr_ff];
   assign do_push = advance & push.valid;
   assign do_pop = rsp_valid & !rsp_stall;
   assign zero_result = '0;

   always_comb begin
      push_n = '0;
      if (do_push) begin
         push_n = push.lead_zero ? FifoCountWidth'(2) : FifoCountWidth'(1);
      end
      wr_ptr_in = wr_ptr_ff + FifoPtrWidth'(push_n);
      rd_ptr_in = do_pop ? rd_ptr_ff + FifoPtrWidth'(1) : rd_ptr_ff;
      count_in = count_ff + push_n - FifoCountWidth'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         if (push.lead_zero) begin
            mem_ff[wr_ptr_ff] <= zero_result;
            mem_ff[wr_ptr_ff + FifoPtrWidth'(1)] <= push.result;
         end else begin
            mem_ff[wr_ptr_ff] <= push.result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/sampled_data_integrator_unit.sv
// Streaming integrator over sets of signed 24-bit samples.
// req channel: one sample per transaction, final_sample marks the end of a set
// (a set is also closed at its MAX_SAMPLES-th sample). rsp channel: integral
// results, signed Q.16, saturated to 64 bits. csr port: method at byte 0,
// step_width (Q8.16, zero taken as 1.0) at byte 4; write only while idle.
// Rectangle, trapezoid and Simpson modes give one result per set on its last
// sample. Cumulative mode gives the running trapezoid sum from the second
// sample on; the second sample of a set gives a zero result first.
// Pipeline: a sample passes the input register, the numerator register, then
// six scaling stages (the 52 x 24 multiply is split into 24 x 24 and 28 x 24
// partial products, divide by 3 is done with reciprocal multiplies) and a
// 4-entry result queue on its way to rsp_valid.
// Throughput: one sample per cycle, sustained while rsp_stall is low; the
// queue absorbs the extra result of the cumulative start.
// rsp_stall: the pipeline holds as a whole while the queue has fewer than two
// free entries, and req_stall is raised for that time.
// Reset: method trapezoid, step 1.0, set index zero, pipeline and queue
// empty; no clearing pass, samples are taken in the first cycle after reset.
module sampled_data_integrator_unit import sdi_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_payload_type         req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_payload_type         rsp_payload,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type      cfg;
   num_item_type item;
   push_type     push;
   logic         advance;

   assign req_stall = !advance;

   sdi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdi_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .item        (item)
   );

   sdi_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .push    (push)
   );

   sdi_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
